[sv/hmn_pkg.sv]
`timescale 1ns / 1ps

package hmn_pkg;

  localparam int GRID_SIZE = 64;
  localparam int GRID_W    = $clog2(GRID_SIZE);

  localparam int HEIGHT_W  = 32;
  localparam int STEP_W    = 24;
  localparam int NORM_W    = 16;
  localparam int COORD_W   = 6;

  // |dh| * step needs 32 + 24 bits
  localparam int MAG_W     = 56;
  localparam int MUL_W     = 32;
  localparam int SUB_W     = 36;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4369);

  localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sh7FFF;
  localparam logic signed [NORM_W-1:0] NORM_MIN = 16'sh8000;

  typedef logic [GRID_W-1:0]  idx_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_ZW,
    ST_NORM,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_DONE,
    ST_EMIT
  } state_t;

endpackage

[sv/heightmap_normal_generator.sv]
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid / in_ready | height (s32 Q16.16), raster order
// output   | out_valid/out_ready | grid_row, grid_col, normal_x/y/z (s16 Q1.15),
//          |                     | run_last, frame_last
// config   | cfg_we              | cfg_data (u24 Q8.16 grid step)
//
// A row-0 sample only fills the line buffer; a last-column sample, and after
// its differences a zero-step sample, goes to emit. An inner sample runs the
// products, a normalizing right shift by k = 0..25 and the squares on one
// 32x32 multiplier, then the 32-step square root and three 16-step divisions
// that share one compare/subtract unit. The last row also emits a copy of each.
// Reset: synchronous, clears counters, sequencer, output valid and the
// remembered normal; grid_step returns to 4369. The line buffer is not cleared.
// Stalls: in_ready is high only in the idle state; the output register holds
// a result until taken, and the idle block accepts new samples meanwhile.

module heightmap_normal_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hmn_pkg::STEP_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hmn_pkg::HEIGHT_W-1:0] height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hmn_pkg::COORD_W-1:0]         grid_row,
  output logic [hmn_pkg::COORD_W-1:0]         grid_col,
  output logic signed [hmn_pkg::NORM_W-1:0]   normal_x,
  output logic signed [hmn_pkg::NORM_W-1:0]   normal_y,
  output logic signed [hmn_pkg::NORM_W-1:0]   normal_z,
  output logic                                run_last,
  output logic                                frame_last
);

  localparam hmn_pkg::idx_t LAST_IDX = hmn_pkg::idx_t'(hmn_pkg::GRID_SIZE - 1);

  hmn_pkg::state_t state, state_next;

  // configuration
  logic [hmn_pkg::STEP_W-1:0] grid_step;

  // position of the next sample and the one being worked on
  hmn_pkg::idx_t row_count, col_count;
  hmn_pkg::idx_t r_reg, c_reg;

  // line buffer
  logic [hmn_pkg::HEIGHT_W-1:0] row_store [hmn_pkg::GRID_SIZE];
  hmn_pkg::idx_t                rd_addr;
  logic [hmn_pkg::HEIGHT_W-1:0] rd_data;
  logic                         in_take;

  // datapath registers
  logic signed [hmn_pkg::HEIGHT_W-1:0] h_reg, here;
  logic [hmn_pkg::MUL_W-1:0]           abs_x, abs_y;
  logic [2:0]                          neg;
  logic [hmn_pkg::MAG_W-1:0]           mag0, mag1, mag2;
  logic [2*hmn_pkg::MUL_W-1:0]         prod, sum;
  logic [33:0]                         sq_rem;
  logic [31:0]                         root;
  logic [31:0]                         div_rem;
  logic [15:0]                         div_low, quo;
  logic [4:0]                          step_cnt;
  logic [1:0]                          comp;
  logic                                emit_idx;
  logic signed [hmn_pkg::NORM_W-1:0]   prior_normal [3];

  // shared multiplier and compare/subtract unit
  logic [hmn_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [hmn_pkg::SUB_W-1:0] sub_a, sub_b, sub_diff;
  logic                      sub_ge;

  // forward differences
  logic signed [hmn_pkg::HEIGHT_W:0] dx, dy;
  logic [hmn_pkg::HEIGHT_W:0]        dx_abs, dy_abs;

  logic [hmn_pkg::MAG_W-1:0] mag_big, mag_sel;
  logic [46:0]               div_num;
  logic [15:0]               quo_neg;
  logic                      out_load;
  logic                      corner;

  assign sub_diff = sub_a - sub_b;
  assign sub_ge   = (sub_a >= sub_b);

  assign dx     = {h_reg[hmn_pkg::HEIGHT_W-1], h_reg} - {here[hmn_pkg::HEIGHT_W-1], here};
  assign dy     = {rd_data[hmn_pkg::HEIGHT_W-1], rd_data} - {here[hmn_pkg::HEIGHT_W-1], here};
  assign dx_abs = dx[hmn_pkg::HEIGHT_W] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[hmn_pkg::HEIGHT_W] ? (~dy + 1'b1) : dy;

  assign mag_big = mag0 | mag1 | mag2;

  always_comb begin
    case (comp)
      2'd0:    mag_sel = mag0;
      2'd1:    mag_sel = mag1;
      default: mag_sel = mag2;
    endcase
  end

  // scaled component plus half the length, for round-half-up
  assign div_num = {1'b0, mag_sel[30:0], 15'b0} + {16'b0, root[31:1]};
  assign quo_neg = ~quo + 1'b1;

  assign in_take = in_valid && in_ready;
  assign corner  = (c_reg == LAST_IDX) && emit_idx;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hmn_pkg::ST_IDLE: begin
        if (in_take) begin
          if (row_count == '0)
            state_next = hmn_pkg::ST_IDLE;
          else if (col_count == LAST_IDX)
            state_next = hmn_pkg::ST_EMIT;
          else
            state_next = hmn_pkg::ST_LOAD;
        end
      end
      hmn_pkg::ST_LOAD:   state_next = hmn_pkg::ST_DIFF;
      hmn_pkg::ST_DIFF:
        state_next = (grid_step == '0) ? hmn_pkg::ST_EMIT : hmn_pkg::ST_MUL_X;
      hmn_pkg::ST_MUL_X:  state_next = hmn_pkg::ST_MUL_Y;
      hmn_pkg::ST_MUL_Y:  state_next = hmn_pkg::ST_MUL_Z;
      hmn_pkg::ST_MUL_Z:  state_next = hmn_pkg::ST_MUL_ZW;
      hmn_pkg::ST_MUL_ZW: state_next = hmn_pkg::ST_NORM;
      hmn_pkg::ST_NORM: begin
        if (mag_big[hmn_pkg::MAG_W-1:31] == '0)
          state_next = hmn_pkg::ST_SQ_X;
      end
      hmn_pkg::ST_SQ_X:   state_next = hmn_pkg::ST_SQ_Y;
      hmn_pkg::ST_SQ_Y:   state_next = hmn_pkg::ST_SQ_Z;
      hmn_pkg::ST_SQ_Z:   state_next = hmn_pkg::ST_SQ_ACC;
      hmn_pkg::ST_SQ_ACC: state_next = hmn_pkg::ST_SQRT;
      hmn_pkg::ST_SQRT: begin
        if (step_cnt == '0)
          state_next = hmn_pkg::ST_DIV_INIT;
      end
      hmn_pkg::ST_DIV_INIT: state_next = hmn_pkg::ST_DIV;
      hmn_pkg::ST_DIV: begin
        if (step_cnt == '0)
          state_next = hmn_pkg::ST_DIV_DONE;
      end
      hmn_pkg::ST_DIV_DONE:
        state_next = (comp == 2'd2) ? hmn_pkg::ST_EMIT : hmn_pkg::ST_DIV_INIT;
      hmn_pkg::ST_EMIT: begin
        if (out_load && !((r_reg == LAST_IDX) && !emit_idx))
          state_next = hmn_pkg::ST_IDLE;
      end
      default: state_next = hmn_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, buffer address, shared unit operands
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    rd_addr  = col_count;
    mul_a    = '0;
    mul_b    = '0;
    sub_a    = '0;
    sub_b    = '0;
    case (state)
      hmn_pkg::ST_IDLE: in_ready = 1'b1;
      hmn_pkg::ST_LOAD: rd_addr = hmn_pkg::idx_t'(c_reg + 1'b1);
      hmn_pkg::ST_MUL_X: begin
        mul_a = abs_x;
        mul_b = hmn_pkg::MUL_W'(grid_step);
      end
      hmn_pkg::ST_MUL_Y: begin
        mul_a = abs_y;
        mul_b = hmn_pkg::MUL_W'(grid_step);
      end
      hmn_pkg::ST_MUL_Z: begin
        mul_a = hmn_pkg::MUL_W'(grid_step);
        mul_b = hmn_pkg::MUL_W'(grid_step);
      end
      hmn_pkg::ST_SQ_X: begin
        mul_a = hmn_pkg::MUL_W'(mag0[30:0]);
        mul_b = hmn_pkg::MUL_W'(mag0[30:0]);
      end
      hmn_pkg::ST_SQ_Y: begin
        mul_a = hmn_pkg::MUL_W'(mag1[30:0]);
        mul_b = hmn_pkg::MUL_W'(mag1[30:0]);
      end
      hmn_pkg::ST_SQ_Z: begin
        mul_a = hmn_pkg::MUL_W'(mag2[30:0]);
        mul_b = hmn_pkg::MUL_W'(mag2[30:0]);
      end
      hmn_pkg::ST_SQRT: begin
        sub_a = {sq_rem, sum[63:62]};
        sub_b = {2'b0, root, 2'b01};
      end
      hmn_pkg::ST_DIV: begin
        sub_a = hmn_pkg::SUB_W'({div_rem, div_low[15]});
        sub_b = hmn_pkg::SUB_W'(root);
      end
      hmn_pkg::ST_EMIT: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= hmn_pkg::ST_IDLE;
    else
      state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst)
      grid_step <= hmn_pkg::STEP_RESET;
    else if (cfg_we)
      grid_step <= cfg_data;
  end

  // line buffer: the read returns the old entry when the same column is written
  always_ff @(posedge clk) begin
    if (in_take)
      row_store[col_count] <= height;
    rd_data <= row_store[rd_addr];
  end

  // advance the raster position on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_take) begin
      if (col_count == LAST_IDX) begin
        col_count <= '0;
        row_count <= (row_count == LAST_IDX) ? '0 : hmn_pkg::idx_t'(row_count + 1'b1);
      end else begin
        col_count <= hmn_pkg::idx_t'(col_count + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      hmn_pkg::ST_IDLE: begin
        if (in_take) begin
          h_reg <= height;
          r_reg <= row_count;
          c_reg <= col_count;
        end
      end
      hmn_pkg::ST_LOAD: here <= rd_data;
      hmn_pkg::ST_DIFF: begin
        abs_x <= dx_abs[hmn_pkg::MUL_W-1:0];
        abs_y <= dy_abs[hmn_pkg::MUL_W-1:0];
        neg   <= {1'b0, (!dy[hmn_pkg::HEIGHT_W] && (dy != '0)),
                  (!dx[hmn_pkg::HEIGHT_W] && (dx != '0))};
      end
      hmn_pkg::ST_MUL_Y:  mag0 <= prod[hmn_pkg::MAG_W-1:0];
      hmn_pkg::ST_MUL_Z:  mag1 <= prod[hmn_pkg::MAG_W-1:0];
      hmn_pkg::ST_MUL_ZW: mag2 <= prod[hmn_pkg::MAG_W-1:0];
      hmn_pkg::ST_NORM: begin
        if (mag_big[hmn_pkg::MAG_W-1:31] != '0) begin
          mag0 <= mag0 >> 1;
          mag1 <= mag1 >> 1;
          mag2 <= mag2 >> 1;
        end
      end
      hmn_pkg::ST_SQ_Y: sum <= prod;
      hmn_pkg::ST_SQ_Z: sum <= sum + prod;
      hmn_pkg::ST_SQ_ACC: begin
        sum      <= sum + prod;
        sq_rem   <= '0;
        root     <= '0;
        step_cnt <= 5'd31;
      end
      hmn_pkg::ST_SQRT: begin
        // one root digit per cycle, two radicand bits at a time
        if (sub_ge) begin
          sq_rem <= sub_diff[33:0];
          root   <= {root[30:0], 1'b1};
        end else begin
          sq_rem <= sub_a[33:0];
          root   <= {root[30:0], 1'b0};
        end
        sum      <= sum << 2;
        step_cnt <= step_cnt - 1'b1;
        comp     <= 2'd0;
      end
      hmn_pkg::ST_DIV_INIT: begin
        div_rem  <= {1'b0, div_num[46:16]};
        div_low  <= div_num[15:0];
        quo      <= '0;
        step_cnt <= 5'd15;
      end
      hmn_pkg::ST_DIV: begin
        if (sub_ge) begin
          div_rem <= sub_diff[31:0];
          quo     <= {quo[14:0], 1'b1};
        end else begin
          div_rem <= sub_a[31:0];
          quo     <= {quo[14:0], 1'b0};
        end
        div_low  <= div_low << 1;
        step_cnt <= step_cnt - 1'b1;
      end
      hmn_pkg::ST_DIV_DONE: comp <= comp + 1'b1;
      default: ;
    endcase
  end

  // remembered normal: written by the divider, or straight up for a zero step
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_normal[0] <= '0;
      prior_normal[1] <= '0;
      prior_normal[2] <= '0;
    end else if ((state == hmn_pkg::ST_DIFF) && (grid_step == '0)) begin
      prior_normal[0] <= '0;
      prior_normal[1] <= '0;
      prior_normal[2] <= hmn_pkg::NORM_MAX;
    end else if (state == hmn_pkg::ST_DIV_DONE) begin
      // saturate: negative side may reach -1.0, positive side stops below 1.0
      if (neg[comp])
        prior_normal[comp] <= (quo > 16'd32768) ? hmn_pkg::NORM_MIN : signed'(quo_neg);
      else
        prior_normal[comp] <= (quo > 16'd32767) ? hmn_pkg::NORM_MAX : signed'(quo);
    end
  end

  // emit index: second result fills the last row (copied normal, corner up)
  always_ff @(posedge clk) begin
    if (rst)
      emit_idx <= 1'b0;
    else if (out_load)
      emit_idx <= (r_reg == LAST_IDX) && !emit_idx;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (out_load)
      out_valid <= 1'b1;
    else if (out_ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      grid_row   <= emit_idx ? hmn_pkg::coord_t'(r_reg)
                             : hmn_pkg::coord_t'(hmn_pkg::idx_t'(r_reg - 1'b1));
      grid_col   <= hmn_pkg::coord_t'(c_reg);
      normal_x   <= corner ? '0 : prior_normal[0];
      normal_y   <= corner ? '0 : prior_normal[1];
      normal_z   <= corner ? hmn_pkg::NORM_MAX : prior_normal[2];
      run_last   <= emit_idx || (r_reg != LAST_IDX);
      frame_last <= corner;
    end
  end

endmodule

[dv/tb_heightmap_normal_generator.sv]
`timescale 1ns / 1ps

module tb_heightmap_normal_generator;
  import hmn_pkg::*;

  // The opening row plus some two dozen rows of inner points and last columns.
  localparam int N_ITEMS       = 1750;
  localparam int N_SEGMENTS    = 6;
  localparam int SEG_LEN       = N_ITEMS / N_SEGMENTS;
  localparam int DIRECTED_N    = 25;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int HOLD_AFTER    = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    coord_t                   row;
    coord_t                   col;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     run_last;
    logic                     frame_last;
  } normal_t;

  // Tracks the grid position, the line buffer and the step, and keeps the
  // normals still owed by the block in arrival order.
  class normal_tracker;
    logic [STEP_W-1:0]          step;
    logic signed [HEIGHT_W-1:0] line_buf [GRID_SIZE];
    int unsigned                row_pos;
    int unsigned                col_pos;
    vec3_t                      last_n;
    normal_t                    pending_normals [$];
    int unsigned                errors;

    function new();
      step    = STEP_RESET;
      row_pos = 0;
      col_pos = 0;
      last_n  = '0;
      errors  = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // Unit vector along (-s*dx, -s*dy, s*s), scaled to Q1.15 and saturated.
    function vec3_t unit_normal(longint dx, longint dy);
      longint unsigned s;
      longint unsigned mx;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      longint unsigned mag [3];
      bit                       neg [3];
      logic signed [NORM_W-1:0] comp [3];
      int unsigned              k;
      vec3_t                    n;
      s      = step;
      neg[0] = dx > 0;
      neg[1] = dy > 0;
      neg[2] = 1'b0;
      mag[0] = ((dx < 0) ? -dx : dx) * s;
      mag[1] = ((dy < 0) ? -dy : dy) * s;
      mag[2] = s * s;
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
      // Zero step: nothing to normalize, point straight up.
      if (mx == 0) begin
        n.x = '0;
        n.y = '0;
        n.z = NORM_MAX;
        return n;
      end
      // Shift all three down until the largest fits in 31 bits.
      k = 0;
      while ((mx >> k) >= 64'h8000_0000) k++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> k;
        sum += mag[i] * mag[i];
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 64'd32768 + len / 2) / len;
        if (neg[i]) comp[i] = (q > 64'd32768) ? NORM_MIN : NORM_W'(64'd0 - q);
        else        comp[i] = (q > 64'd32767) ? NORM_MAX : NORM_W'(q);
      end
      n.x = comp[0];
      n.y = comp[1];
      n.z = comp[2];
      return n;
    endfunction

    function normal_t make_entry(int unsigned r, int unsigned c, vec3_t n, bit last, bit frame);
      normal_t e;
      e.row        = COORD_W'(r);
      e.col        = COORD_W'(c);
      e.nx         = n.x;
      e.ny         = n.y;
      e.nz         = n.z;
      e.run_last   = last;
      e.frame_last = frame;
      return e;
    endfunction

    // Book one accepted height: queue the normals it completes, then advance.
    function void take_height(logic signed [HEIGHT_W-1:0] h);
      longint here;
      longint dx;
      longint dy;
      vec3_t  n;
      vec3_t  up;
      bit     last_row;
      up.x     = '0;
      up.y     = '0;
      up.z     = NORM_MAX;
      last_row = (row_pos == GRID_SIZE - 1);
      // Row 0 only fills the line buffer.
      if (row_pos != 0) begin
        if (col_pos < GRID_SIZE - 1) begin
          here = line_buf[col_pos];
          dx   = longint'(h) - here;
          dy   = longint'(line_buf[col_pos + 1]) - here;
          n    = unit_normal(dx, dy);
          last_n = n;
          pending_normals.push_back(make_entry(row_pos - 1, col_pos, n, !last_row, 1'b0));
          // Last row copies the row above.
          if (last_row)
            pending_normals.push_back(make_entry(row_pos, col_pos, n, 1'b1, 1'b0));
        end else begin
          // Last column repeats the normal of the column before it.
          pending_normals.push_back(make_entry(row_pos - 1, col_pos, last_n, !last_row, 1'b0));
          // Far corner points straight up and closes the grid.
          if (last_row)
            pending_normals.push_back(make_entry(row_pos, col_pos, up, 1'b1, 1'b1));
        end
      end
      line_buf[col_pos] = h;
      col_pos++;
      if (col_pos == GRID_SIZE) begin
        col_pos = 0;
        row_pos++;
        if (row_pos == GRID_SIZE) row_pos = 0;
      end
    endfunction

    function void compare_normal(normal_t got);
      normal_t want;
      if (pending_normals.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected normal: row %0d col %0d (%0d,%0d,%0d) last %0b frame %0b",
                   got.row, got.col, got.nx, got.ny, got.nz, got.run_last, got.frame_last);
        return;
      end
      want = pending_normals.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("normal mismatch: expected row %0d col %0d (%0d,%0d,%0d) last %0b frame %0b",
                   want.row, want.col, want.nx, want.ny, want.nz, want.run_last,
                   want.frame_last);
          $display("                 actual   row %0d col %0d (%0d,%0d,%0d) last %0b frame %0b",
                   got.row, got.col, got.nx, got.ny, got.nz, got.run_last, got.frame_last);
        end
      end
    endfunction
  endclass

  // Block ports; every input starts at a known value.
  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic [STEP_W-1:0]           cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic signed [HEIGHT_W-1:0]  height    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [COORD_W-1:0]          grid_row;
  logic [COORD_W-1:0]          grid_col;
  logic signed [NORM_W-1:0]    normal_x;
  logic signed [NORM_W-1:0]    normal_y;
  logic signed [NORM_W-1:0]    normal_z;
  logic                        run_last;
  logic                        frame_last;

  normal_tracker normals;
  normal_t       seen_normal;
  int unsigned   send_idle_pct = 25;
  int unsigned   recv_idle_pct = 71;
  int unsigned   results_taken = 0;
  int unsigned   hold_left     = 0;
  bit            hold_done     = 1'b0;
  int unsigned   quiet_cycles  = 0;

  // Edge heights for the opening row: extremes, alternating bits, one LSB.
  logic signed [HEIGHT_W-1:0] edge_heights [DIRECTED_N] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000,
    32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h7FFF_0000,
    32'h8001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_FFFF, 32'h1234_5678,
    32'hEDCB_A988, 32'h4000_0000, 32'hC000_0000, 32'h0000_0000, 32'hFFFF_FFFF
  };

  heightmap_normal_generator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .height     (height),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grid_row   (grid_row),
    .grid_col   (grid_col),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .run_last   (run_last),
    .frame_last (frame_last)
  );

  always #5 clk = ~clk;

  // Mostly a random walk so that differences span every scale, mixed with
  // full-range noise, rail values and flat stretches.
  function automatic logic signed [HEIGHT_W-1:0] pick_height(logic signed [HEIGHT_W-1:0] prev);
    int unsigned                sel;
    int unsigned                sh;
    logic signed [HEIGHT_W-1:0] delta;
    sel   = $urandom_range(0, 9);
    sh    = $urandom_range(0, 26);
    delta = $signed($urandom) >>> (31 - sh);
    case (sel)
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3:       return prev;
      default: return prev + delta;
    endcase
  endfunction

  // Offer one height and hold it until the input transaction completes.
  // Drop valid only while idling, so it never falls and rises in one step.
  task automatic send_height(logic signed [HEIGHT_W-1:0] h);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    height   <= h;
    do @(posedge clk); while (!in_ready);
    normals.take_height(h);
  endtask

  // Drain every owed normal, let a trailing row-0 sample finish, then write.
  task automatic write_step(logic [STEP_W-1:0] value);
    in_valid <= 1'b0;
    while (normals.pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    normals.step = value;
  endtask

  // Result side: check each output transaction, randomize ready, and once
  // hold ready low long enough for the block to back up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_normal = '{grid_row, grid_col, normal_x, normal_y, normal_z, run_last, frame_last};
        normals.compare_normal(seen_normal);
        results_taken++;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [HEIGHT_W-1:0] h;
    logic signed [HEIGHT_W-1:0] prev;
    int                         seg;
    normals = new();
    prev    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The first segment runs on the reset step; later ones walk the step
    // through its extremes, zero, one unit and random values.
    for (int i = 0; i < N_ITEMS; i++) begin
      if (i == N_ITEMS / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 25;
      end
      if (i == 2 * N_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i != 0 && i % SEG_LEN == 0) begin
        seg = i / SEG_LEN;
        case (seg)
          1:       write_step(24'hFF_FFFF);
          2:       write_step(24'h00_0001);
          3:       write_step(24'h00_0000);
          4:       write_step(24'h01_0000);
          default: write_step(STEP_W'($urandom_range(1, 24'hFF_FFFF)));
        endcase
      end
      h = (i < DIRECTED_N) ? edge_heights[i] : pick_height(prev);
      send_height(h);
      prev = h;
    end
    in_valid <= 1'b0;

    // Wait out the owed normals, then a margin for anything stray.
    while (normals.pending_normals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (normals.errors == 0 && normals.pending_normals.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[heightmap_normal_generator.f]
sv/hmn_pkg.sv
sv/heightmap_normal_generator.sv
dv/tb_heightmap_normal_generator.sv
